>>> design/arrt_pkg.sv
package arrt_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int PAGE_BITS = 12;
  localparam int ADDR_BITS = 32;
  localparam int OFFS_W = 32;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int WIDE_W = ADDR_BITS + 2;

  typedef logic [WIDE_W-1:0] wide_t;

  localparam wide_t PAGE_MASK = wide_t'((64'd1 << PAGE_BITS) - 64'd1);
  localparam wide_t USER_LOW = wide_t'(64'h0000_1000);
  localparam wide_t USER_HIGH = wide_t'(64'h8000_0000);
  localparam wide_t MMAP_BASE = wide_t'(64'h6000_0000);

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_LOOKUP,
    CMD_GAP
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_BUSY,
    ST_NOTFOUND
  } status_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] lim;
    logic [2:0]           prot;
    logic [7:0]           flags;
    logic [15:0]          obj;
    logic [OFFS_W-1:0]    offs;
  } entry_t;

  function automatic wide_t pg_down(wide_t v);
    return v & ~PAGE_MASK;
  endfunction

  function automatic wide_t pg_up(wide_t v);
    return (v + PAGE_MASK) & ~PAGE_MASK;
  endfunction

endpackage

>>> design/arrt_cell.sv
module arrt_cell import arrt_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> design/arrt_chain.sv
module arrt_chain import arrt_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  entry_t push,
  output entry_t head
);

  entry_t cq [MAX_REGIONS];

  genvar k;
  generate
    for (k = 0; k < MAX_REGIONS; k++) begin : g_cell
      if (k == MAX_REGIONS - 1) begin : g_tail
        arrt_cell u_cell (.clk(clk), .shift(shift), .d(push), .q(cq[k]));
      end else begin : g_mid
        arrt_cell u_cell (.clk(clk), .shift(shift), .d(cq[k+1]), .q(cq[k]));
      end
    end
  endgenerate

  assign head = cq[0];

endmodule

>>> design/address_range_region_table.sv
// Add and lookup answer after a single walk of the cell chain.
// Requests rejected before any walk answer from S_CHK, or also from S_GCHK for a gap search.
// Remove walks the chain once, plus once more for each region it deletes.
// Gap search walks the chain once, plus once more for each region it skips.
// One request at a time; every walk rotates the whole cell chain once plus one step.
// Reset (synchronous, active high) empties the table; entries hold no reset value.
module address_range_region_table import arrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [31:0]          address,
  input  logic [31:0]          length,
  input  logic [2:0]           protection,
  input  logic [7:0]           map_flags,
  input  logic [15:0]          object_tag,
  input  logic [31:0]          backing_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [31:0]          result_address,
  output logic [31:0]          hit_end,
  output logic [2:0]           hit_protection,
  output logic [7:0]           hit_flags,
  output logic [15:0]          hit_object,
  output logic [31:0]          hit_offset
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHK,
    S_GCHK,
    S_WALK,
    S_POST,
    S_OUT
  } state_t;

  state_t state;
  cmd_t cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] len;
  entry_t new_ent;
  wide_t s_r, e_r, span, lenup;
  logic [CNT_W-1:0] count, p;
  logic found, del_w, split_w, full_err, rm_hit;
  entry_t hit_r, q0, q1;
  logic [1:0] qn;

  entry_t head, push, p0, p1, c0, c1, c2, q0_next, q1_next;
  entry_t ent_front, ent_back, ent_b;
  wide_t hs, hl, rs, re, d_front, d_split;
  logic hv, ov, lk, touch, del_now, split_now, full_now, last_step;
  logic [1:0] pn, cn, qn_next;

  arrt_chain u_chain (
    .clk(clk),
    .shift(state == S_WALK),
    .push(push),
    .head(head)
  );

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign last_step = (p == CNT_W'(MAX_REGIONS));

  always_comb begin
    hs = wide_t'(head.start);
    hl = wide_t'(head.lim);
    hv = (p < count);
    ov = hv && !((e_r <= hs) || (s_r >= hl));
    lk = hv && (addr >= head.start) && (addr < head.lim);
    rs = (s_r > hs) ? s_r : hs;
    re = (e_r < hl) ? e_r : hl;
    touch = hv && (re > rs);
    d_front = re - rs;
    d_split = re - hs;
    ent_front = head;
    ent_front.start = re[ADDR_BITS-1:0];
    ent_front.offs = head.offs + d_front[OFFS_W-1:0];
    ent_back = head;
    ent_back.lim = rs[ADDR_BITS-1:0];
    ent_b = head;
    ent_b.start = re[ADDR_BITS-1:0];
    ent_b.offs = head.offs + d_split[OFFS_W-1:0];

    pn = 2'd0;
    p0 = head;
    p1 = head;
    del_now = 1'b0;
    split_now = 1'b0;
    full_now = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (hv) begin
          pn = 2'd1;
        end else if (p == count && !found) begin
          pn = 2'd1;
          p0 = new_ent;
        end
      end
      CMD_REMOVE: begin
        if (touch) begin
          if (rs == hs && re == hl) begin
            if (!del_w) begin
              del_now = 1'b1;
            end else begin
              pn = 2'd1;
            end
          end else if (rs == hs) begin
            pn = 2'd1;
            p0 = ent_front;
          end else if (re == hl) begin
            pn = 2'd1;
            p0 = ent_back;
          end else if (count >= CNT_W'(MAX_REGIONS)) begin
            pn = 2'd1;
            full_now = 1'b1;
          end else begin
            pn = 2'd2;
            p0 = ent_back;
            p1 = ent_b;
            split_now = 1'b1;
          end
        end else if (hv) begin
          pn = 2'd1;
        end
      end
      default: begin
        if (hv) begin
          pn = 2'd1;
        end
      end
    endcase

    cn = qn + pn;
    case (qn)
      2'd0: begin
        c0 = p0;
        c1 = p1;
        c2 = p1;
      end
      2'd1: begin
        c0 = q0;
        c1 = p0;
        c2 = p1;
      end
      default: begin
        c0 = q0;
        c1 = q1;
        c2 = p0;
      end
    endcase

    if (p == '0 || cn == 2'd0) begin
      push = head;
    end else begin
      push = c0;
    end

    if (p == '0) begin
      q0_next = c0;
      q1_next = c1;
      qn_next = cn;
    end else if (cn == 2'd0) begin
      q0_next = q0;
      q1_next = q1;
      qn_next = 2'd0;
    end else begin
      q0_next = c1;
      q1_next = c2;
      qn_next = cn - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= cmd_t'(command);
            addr <= address;
            len <= length;
            new_ent.prot <= protection;
            new_ent.flags <= map_flags;
            new_ent.obj <= object_tag;
            new_ent.offs <= backing_offset;
            status <= ST_OK;
            result_address <= '0;
            hit_end <= '0;
            hit_protection <= '0;
            hit_flags <= '0;
            hit_object <= '0;
            hit_offset <= '0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (cmd == CMD_GAP) begin
            s_r <= pg_up(wide_t'(addr));
          end else begin
            s_r <= pg_down(wide_t'(addr));
          end
          e_r <= pg_up(wide_t'(addr) + wide_t'(len));
          lenup <= pg_up(wide_t'(len));
          state <= S_CHK;
        end
        S_CHK: begin
          rm_hit <= 1'b0;
          new_ent.start <= s_r[ADDR_BITS-1:0];
          new_ent.lim <= e_r[ADDR_BITS-1:0];
          p <= '0;
          found <= 1'b0;
          qn <= 2'd0;
          del_w <= 1'b0;
          split_w <= 1'b0;
          full_err <= 1'b0;
          case (cmd)
            CMD_ADD: begin
              if (len == '0 || s_r < USER_LOW || e_r <= s_r || e_r > USER_HIGH) begin
                status <= ST_INVALID;
                state <= S_OUT;
              end else if (count >= CNT_W'(MAX_REGIONS)) begin
                status <= ST_BUSY;
                state <= S_OUT;
              end else begin
                state <= S_WALK;
              end
            end
            CMD_REMOVE: begin
              if (len == '0 || e_r <= s_r) begin
                status <= ST_INVALID;
                state <= S_OUT;
              end else begin
                state <= S_WALK;
              end
            end
            CMD_LOOKUP: begin
              state <= S_WALK;
            end
            default: begin
              if (e_r <= s_r) begin
                status <= ST_INVALID;
                state <= S_OUT;
              end else begin
                if (s_r < MMAP_BASE) begin
                  s_r <= MMAP_BASE;
                  e_r <= MMAP_BASE + lenup;
                  span <= lenup;
                end else begin
                  span <= e_r - s_r;
                end
                state <= S_GCHK;
              end
            end
          endcase
        end
        S_GCHK: begin
          p <= '0;
          found <= 1'b0;
          qn <= 2'd0;
          if (e_r < USER_HIGH) begin
            state <= S_WALK;
          end else begin
            status <= ST_NOTFOUND;
            state <= S_OUT;
          end
        end
        S_WALK: begin
          p <= p + CNT_W'(1);
          q0 <= q0_next;
          q1 <= q1_next;
          qn <= qn_next;
          if (((cmd == CMD_LOOKUP) ? lk : ov) && !found) begin
            found <= 1'b1;
            hit_r <= head;
          end
          if (del_now) begin
            del_w <= 1'b1;
          end
          if (split_now) begin
            split_w <= 1'b1;
          end
          if (full_now) begin
            full_err <= 1'b1;
          end
          if (touch) begin
            rm_hit <= 1'b1;
          end
          if (last_step) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          p <= '0;
          found <= 1'b0;
          qn <= 2'd0;
          del_w <= 1'b0;
          split_w <= 1'b0;
          full_err <= 1'b0;
          state <= S_OUT;
          case (cmd)
            CMD_ADD: begin
              if (found) begin
                status <= ST_BUSY;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (full_err) begin
                status <= ST_BUSY;
              end else if (del_w) begin
                count <= count - CNT_W'(1);
                state <= S_WALK;
              end else begin
                count <= count + CNT_W'(split_w);
                status <= rm_hit ? ST_OK : ST_NOTFOUND;
              end
            end
            CMD_LOOKUP: begin
              if (found) begin
                result_address <= hit_r.start;
                hit_end <= hit_r.lim;
                hit_protection <= hit_r.prot;
                hit_flags <= hit_r.flags;
                hit_object <= hit_r.obj;
                hit_offset <= hit_r.offs;
              end else begin
                status <= ST_NOTFOUND;
              end
            end
            default: begin
              if (found) begin
                s_r <= wide_t'(hit_r.lim);
                e_r <= wide_t'(hit_r.lim) + span;
                state <= S_GCHK;
              end else begin
                result_address <= s_r[ADDR_BITS-1:0];
              end
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
